// ===== rtl/qzsd_pkg.sv =====
// Shared types and constants for the quiet zone span detector.
// No dependencies; every module and the bench import this package.
`default_nettype none

package qzsd_pkg;

    localparam int INDEX_W     = 16;
    localparam int X_W         = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    // Stream length limit; sample indices saturate at min(MAX_SAMPLES-1, 65535).
    localparam longint unsigned MAX_SAMPLES = 64'd65536;
    localparam logic [INDEX_W-1:0] INDEX_CAP =
        ((MAX_SAMPLES - 64'd1) > 64'd65535) ? 16'hFFFF : 16'(MAX_SAMPLES - 64'd1);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SPAN_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDEN_BY_ONE   = 1'd1;

    typedef struct packed {
        logic                  event_flag;
        logic signed [X_W-1:0] sample_x;
        logic                  final_sample;
    } sample_t;

    typedef struct packed {
        logic [INDEX_W-1:0] zone_first;
        logic [INDEX_W-1:0] zone_final;
    } zone_result_t;

    // Pipeline handshake between stages
    typedef struct packed {
        logic step;     // stage-1 transaction moves into the tracker this cycle
        logic advance;  // output register can take a new value this cycle
    } pipe_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/qzsd_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transaction.
// Payload type is a parameter; used with qzsd_pkg structs.
`default_nettype none

interface qzsd_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/quiet_zone_span_detector_unit.sv =====
// Top level of the quiet zone span detector.
// Depends on qzsd_pkg, qzsd_stream_if and the qzsd_* stage modules.
`default_nettype none

// Quiet zone span detector. One sample transaction per cycle enters on
// "samples" (event_flag, sample_x in signed Q16.16, final_sample). A zone
// is a run of samples with event_flag low; it closes at the next flagged
// sample or at the final sample, and is reported on "zones" (zone_first,
// zone_final) when |x(last) - x(first)| is strictly greater than
// span_threshold (register 0, signed Q16.16, exact 33-bit compare). With
// widen_by_one (register 1) set, a reported zone grows by one sample each
// side, clamped to index 0 and not past the final sample or the index cap.
// Indices saturate at 65535. After a final sample the index restarts at 0;
// registers keep their values and must be written only while idle.
// Throughput is one sample per cycle while zones is not back-pressured. A
// result is loaded into the result register when its sample steps out of
// the input register, which a waiting result can hold back: one input register,
// then the span subtract/compare feeding the result register. A waiting result stalls
// the tracker but one more sample is still taken into the input register.
module quiet_zone_span_detector_unit
    import qzsd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    qzsd_stream_if.sink                 samples,
    qzsd_stream_if.source               zones
);

    pipe_ctrl_t   ctrl;
    sample_t      sample;
    logic         advance;
    logic         result_valid;
    zone_result_t result;

    // Stage 1: accepted sample transaction
    qzsd_input_stage u_input (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .advance (advance),
        .ctrl    (ctrl),
        .sample  (sample)
    );

    // Zone state and span test
    qzsd_zone_tracker u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ctrl         (ctrl),
        .sample       (sample),
        .result_valid (result_valid),
        .result       (result)
    );

    // Stage 2: result register toward the consumer
    qzsd_output_stage u_output (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .result_valid (result_valid),
        .result       (result),
        .zones        (zones),
        .advance      (advance)
    );

endmodule

`default_nettype wire

// ===== rtl/qzsd_input_stage.sv =====
// Input register for sample transactions.
// Depends on qzsd_pkg and qzsd_stream_if.
`default_nettype none

module qzsd_input_stage
    import qzsd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    qzsd_stream_if.sink samples,
    input  wire logic   advance,
    output pipe_ctrl_t  ctrl,
    output sample_t     sample
);

    logic    stage_valid_reg;
    logic    stage_valid_next;
    sample_t stage_payload_reg;
    logic    take;

    assign samples.ready = !stage_valid_reg || advance;
    assign take          = samples.valid && samples.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (samples.ready)
        begin
            stage_valid_next = samples.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_payload_reg <= samples.payload;
        end
    end

    assign ctrl.step    = stage_valid_reg && advance;
    assign ctrl.advance = advance;
    assign sample       = stage_payload_reg;

endmodule

`default_nettype wire

// ===== rtl/qzsd_zone_tracker.sv =====
// Zone state, configuration registers and the close/report decision.
// Depends on qzsd_pkg.
`default_nettype none

module qzsd_zone_tracker
    import qzsd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire pipe_ctrl_t             ctrl,
    input  wire sample_t                sample,
    output logic                        result_valid,
    output zone_result_t                result
);

    logic signed [X_W-1:0] span_threshold_reg;
    logic                  widen_by_one_reg;

    logic                  in_zone_reg,          in_zone_next;
    logic [INDEX_W-1:0]    zone_begin_index_reg, zone_begin_index_next;
    logic [X_W-1:0]        zone_begin_x_reg,     zone_begin_x_next;
    logic [X_W-1:0]        previous_x_reg,       previous_x_next;
    logic [INDEX_W-1:0]    position_reg,         position_next;

    logic                  close_req;
    logic                  at_end;
    logic [INDEX_W-1:0]    first_idx;
    logic [INDEX_W-1:0]    last_idx;
    logic [INDEX_W-1:0]    flag_last;
    logic [X_W-1:0]        first_x;
    logic [X_W-1:0]        last_x;
    logic [X_W:0]          diff;
    logic [X_W:0]          abs_diff;
    logic                  keep;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_threshold_reg <= '0;
            widen_by_one_reg   <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_SPAN_THRESHOLD: span_threshold_reg <= cfg_data;
                REG_WIDEN_BY_ONE:   widen_by_one_reg   <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Close decision. A flagged sample closes the open zone at the previous
    // index; a quiet final sample closes the zone (possibly just opened) at itself.
    always_comb
    begin
        flag_last = (position_reg != '0) ? position_reg - 16'd1 : '0;
        if (flag_last < zone_begin_index_reg)
        begin
            flag_last = zone_begin_index_reg;
        end

        at_end = !sample.event_flag;
        if (sample.event_flag)
        begin
            close_req = in_zone_reg;
            first_idx = zone_begin_index_reg;
            first_x   = zone_begin_x_reg;
            last_idx  = flag_last;
            last_x    = previous_x_reg;
        end
        else
        begin
            close_req = sample.final_sample;
            first_idx = in_zone_reg ? zone_begin_index_reg : position_reg;
            first_x   = in_zone_reg ? zone_begin_x_reg : sample.sample_x;
            last_idx  = position_reg;
            last_x    = sample.sample_x;
        end

        // 33-bit exact span
        diff     = {last_x[X_W-1], last_x} - {first_x[X_W-1], first_x};
        abs_diff = diff[X_W] ? (~diff + 33'd1) : diff;
        keep     = span_threshold_reg[X_W-1] ||
                   (abs_diff > {1'b0, span_threshold_reg});

        if (widen_by_one_reg)
        begin
            if (first_idx != '0)
            begin
                first_idx = first_idx - 16'd1;
            end
            if (!at_end && (last_idx < INDEX_CAP))
            begin
                last_idx = last_idx + 16'd1;
            end
        end

        result_valid      = ctrl.step && close_req && keep;
        result.zone_first = first_idx;
        result.zone_final = last_idx;
    end

    // State update
    always_comb
    begin
        in_zone_next          = in_zone_reg;
        zone_begin_index_next = zone_begin_index_reg;
        zone_begin_x_next     = zone_begin_x_reg;
        previous_x_next       = previous_x_reg;
        position_next         = position_reg;

        if (ctrl.step)
        begin
            if (sample.event_flag)
            begin
                in_zone_next = 1'b0;
            end
            else
            begin
                if (!in_zone_reg)
                begin
                    zone_begin_index_next = position_reg;
                    zone_begin_x_next     = sample.sample_x;
                end
                in_zone_next    = 1'b1;
                previous_x_next = sample.sample_x;
            end

            if (sample.final_sample)
            begin
                position_next = '0;
                in_zone_next  = 1'b0;
            end
            else if (position_reg < INDEX_CAP)
            begin
                position_next = position_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_zone_reg          <= 1'b0;
            zone_begin_index_reg <= '0;
            zone_begin_x_reg     <= '0;
            previous_x_reg       <= '0;
            position_reg         <= '0;
        end
        else
        begin
            in_zone_reg          <= in_zone_next;
            zone_begin_index_reg <= zone_begin_index_next;
            zone_begin_x_reg     <= zone_begin_x_next;
            previous_x_reg       <= previous_x_next;
            position_reg         <= position_next;
        end
    end

    a_zone_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.zone_first <= result.zone_final))
        else $error("reported zone has first index past final index");

    a_position_capped: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= INDEX_CAP)
        else $error("sample index ran past its cap");

    a_stream_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step && sample.final_sample) |=> (position_reg == '0) && !in_zone_reg)
        else $error("stream state not cleared after final sample");

    a_begin_not_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        in_zone_reg |-> (zone_begin_index_reg <= position_reg))
        else $error("open zone starts after current position");

endmodule

`default_nettype wire

// ===== rtl/qzsd_output_stage.sv =====
// Result register driving the zone output channel.
// Depends on qzsd_pkg and qzsd_stream_if.
`default_nettype none

module qzsd_output_stage
    import qzsd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire pipe_ctrl_t   ctrl,
    input  wire logic         result_valid,
    input  wire zone_result_t result,
    qzsd_stream_if.source     zones,
    output logic              advance
);

    logic         out_valid_reg;
    logic         out_valid_next;
    zone_result_t out_payload_reg;

    assign advance = !out_valid_reg || zones.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.advance)
        begin
            out_valid_next = result_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_valid)
        begin
            out_payload_reg <= result;
        end
    end

    assign zones.valid   = out_valid_reg;
    assign zones.payload = out_payload_reg;

endmodule

`default_nettype wire

// ===== bench/quiet_zone_span_detector_unit_test.sv =====
// Self-checking bench for quiet_zone_span_detector_unit: directed, random
// and backpressure streams, checked against an in-bench tracker.
// Depends on qzsd_pkg, qzsd_stream_if and the detector RTL.

module quiet_zone_span_detector_unit_test;
    import qzsd_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;  // several times the slowest legal run
    localparam int DRAIN_LIMIT   = 5000;    // cycles to wait for outstanding zones
    localparam int SETTLE_CYCLES = 4;       // margin for a sample still in flight once no zone is pending

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    qzsd_stream_if #(.payload_t(sample_t))      sample_bus ();
    qzsd_stream_if #(.payload_t(zone_result_t)) zone_bus ();

    quiet_zone_span_detector_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .samples      (sample_bus),
        .zones        (zone_bus)
    );

    // Bench copy of the configuration registers
    logic signed [X_W-1:0] span_thr;
    logic                  widen_on;

    // Zone tracker state, mirrors what the block must hold
    logic                  trk_in_zone;
    logic [INDEX_W-1:0]    trk_begin_index;
    logic signed [X_W-1:0] trk_begin_x;
    logic signed [X_W-1:0] trk_prev_x;
    logic [INDEX_W-1:0]    trk_position;

    // Zones that the tracker says must come out, oldest first
    zone_result_t pending_zones[$];

    int mismatch_count;
    int cycle_count;

    // Idling knobs, changed per test
    int sample_gap_pct;     // chance of a gap before a sample transaction
    int zone_idle_pct;      // chance the receiver starts a stall
    int zone_hold_cycles;   // one-shot long receiver hold-off

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s: expected %0h got %0h (cycle %0d)", what, want, got,
                 cycle_count);
        mismatch_count++;
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // A zone closes: keep it when |x(last) - x(first)| > threshold, then
    // apply the optional widening. The span is exact in 64 bits.
    function automatic void judge_zone(input logic [INDEX_W-1:0] last_idx,
                                       input logic signed [X_W-1:0] last_x,
                                       input logic at_stream_end);
        longint       span;
        zone_result_t r;
        span = longint'(last_x) - longint'(trk_begin_x);
        if (span < 0)
            span = -span;
        if (span > longint'(span_thr))
        begin
            r.zone_first = trk_begin_index;
            r.zone_final = last_idx;
            if (widen_on)
            begin
                if (r.zone_first != '0)
                    r.zone_first = r.zone_first - 1'b1;
                // a zone ended by the final sample keeps that index
                if (!at_stream_end && r.zone_final < INDEX_CAP)
                    r.zone_final = r.zone_final + 1'b1;
            end
            pending_zones = {pending_zones, r};
        end
    endfunction

    // Advance the tracker by one accepted sample transaction
    function automatic void follow_sample(input sample_t s);
        logic [INDEX_W-1:0] pos_now;
        logic [INDEX_W-1:0] last_idx;
        pos_now = trk_position;
        if (s.event_flag)
        begin
            if (trk_in_zone)
            begin
                // zone ends one before the flag; under saturation the flag
                // shares the zone's index, so clamp to the zone start
                last_idx = (pos_now != '0) ? pos_now - 1'b1 : '0;
                if (last_idx < trk_begin_index)
                    last_idx = trk_begin_index;
                judge_zone(last_idx, trk_prev_x, 1'b0);
                trk_in_zone = 1'b0;
            end
        end
        else
        begin
            if (!trk_in_zone)
            begin
                trk_in_zone     = 1'b1;
                trk_begin_index = pos_now;
                trk_begin_x     = s.sample_x;
            end
            trk_prev_x = s.sample_x;
            if (s.final_sample)
            begin
                judge_zone(pos_now, s.sample_x, 1'b1);
                trk_in_zone = 1'b0;
            end
        end
        // a final sample (flagged or not) restarts the stream
        if (s.final_sample)
        begin
            trk_position = '0;
            trk_in_zone  = 1'b0;
        end
        else if (pos_now < INDEX_CAP)
            trk_position = pos_now + 1'b1;
    endfunction

    function automatic sample_t sample_of(input logic flag, input logic [31:0] x,
                                          input logic fin);
        sample_t s;
        s.event_flag   = flag;
        s.sample_x     = x;
        s.final_sample = fin;
        return s;
    endfunction

    // x generator: full range, the extremes, or near a per-stream center so
    // spans land around the threshold
    function automatic logic [31:0] pick_x(input logic [31:0] center,
                                           input int unsigned spread);
        case ($urandom_range(0, 7))
            0: return $urandom();
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return center + $urandom_range(0, 2 * spread) - spread;
        endcase
    endfunction

    // Sends one sample transaction. Entered at a falling edge and returns at
    // the falling edge after acceptance with valid still high, so a following
    // call keeps valid up without a bubble. Anything else that runs next must
    // drop valid in that same step (wait_drained does).
    task automatic send_sample(input sample_t s);
        int gap;
        gap = ($urandom_range(0, 99) < sample_gap_pct) ? idle_len() : 0;
        if (gap > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_bus.valid   <= 1'b1;
        sample_bus.payload <= s;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        follow_sample(s);
        @(negedge clk);
    endtask

    // Stop offering samples and wait until every predicted zone has come
    // out, then let the pipeline settle: a sample that closes nothing may
    // still be in flight.
    task automatic wait_drained();
        int waited;
        waited = 0;
        sample_bus.valid <= 1'b0;
        while (pending_zones.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_zones.size() != 0)
        begin
            report_mismatch("zones never delivered, count", 0, pending_zones.size());
            pending_zones.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes both registers back to back; only called once drained
    task automatic set_config(input logic [31:0] thr, input logic widen);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_SPAN_THRESHOLD;
        cfg_data     <= thr;
        @(negedge clk);
        cfg_index <= REG_WIDEN_BY_ONE;
        cfg_data  <= CFG_DATA_W'(widen);
        @(negedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
        span_thr = thr;
        widen_on = widen;
    endtask

    // Random streams of random length ending mostly in a final sample. A few
    // streams run on without one, and a stray final now and then cuts a
    // stream short.
    task automatic run_streams(input int n_items, input int unsigned spread);
        int          sent;
        int          stream_len;
        int          k;
        logic [31:0] center;
        logic        fin;
        sent = 0;
        while (sent < n_items)
        begin
            stream_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
            center = $urandom();
            for (k = 0; k < stream_len; k++)
            begin
                fin = ((k == stream_len - 1) && ($urandom_range(0, 9) != 0))
                      || ($urandom_range(0, 49) == 0);
                send_sample(sample_of($urandom_range(0, 99) < 30,
                                      pick_x(center, spread), fin));
                sent++;
            end
        end
    endtask

    // Threshold at its top value: a span of 2^31-1 is dropped, 2^31 and
    // above are kept, including the widest span the inputs allow.
    task automatic test_span_extremes();
        wait_drained();
        set_config(32'h7FFF_FFFF, 1'b0);
        sample_gap_pct = 30;
        zone_idle_pct  = 30;
        send_sample(sample_of(1'b0, 32'h8000_0000, 1'b0));
        send_sample(sample_of(1'b0, 32'h7FFF_FFFF, 1'b0));
        send_sample(sample_of(1'b1, 32'h0000_0000, 1'b0));  // kept, span 2^32-1
        send_sample(sample_of(1'b0, 32'h0000_0000, 1'b0));
        send_sample(sample_of(1'b0, 32'h7FFF_FFFF, 1'b0));
        send_sample(sample_of(1'b1, 32'hFFFF_FFFF, 1'b0));  // dropped, equal
        send_sample(sample_of(1'b0, 32'h7FFF_FFFF, 1'b0));
        send_sample(sample_of(1'b0, 32'hFFFF_FFFF, 1'b1));  // kept at stream end
    endtask

    // Threshold at its bottom value keeps every zone; widening is on.
    task automatic test_widening_edges();
        wait_drained();
        set_config(32'h8000_0000, 1'b1);
        // single-sample zone at index 0: first clamps at 0
        send_sample(sample_of(1'b0, 32'h0000_0005, 1'b0));
        send_sample(sample_of(1'b1, 32'h0000_0000, 1'b0));
        // flag with no open zone
        send_sample(sample_of(1'b1, 32'hFFFF_FFFF, 1'b0));
        // zone ended by the final sample keeps the final index
        send_sample(sample_of(1'b0, 32'h1234_0000, 1'b0));
        send_sample(sample_of(1'b0, 32'hFFFF_0000, 1'b0));
        send_sample(sample_of(1'b0, 32'h0001_0000, 1'b1));
        // flagged final closes the open zone at the sample before it
        send_sample(sample_of(1'b0, 32'h8000_0000, 1'b0));
        send_sample(sample_of(1'b1, 32'h7FFF_FFFF, 1'b1));
        // flagged final with nothing open reports nothing
        send_sample(sample_of(1'b1, 32'h0000_0000, 1'b1));
        // one-sample stream
        send_sample(sample_of(1'b0, 32'h7FFF_FFFF, 1'b1));
    endtask

    // The receiver holds off for a long stretch while quiet/flag pairs
    // stream in with no gaps, so result transactions back up and the block
    // must stall its sample input. Then the sender pauses until all is out.
    task automatic test_output_backpressure();
        int k;
        wait_drained();
        set_config(32'hFFFF_FFFF, 1'b0);
        sample_gap_pct   = 0;
        zone_idle_pct    = 10;
        zone_hold_cycles = 200;
        for (k = 0; k < 30; k++)
        begin
            send_sample(sample_of(1'b0, $urandom(), 1'b0));
            send_sample(sample_of(1'b1, $urandom(), k == 29));
        end
        wait_drained();
    endtask

    // Random streams over a sweep of settings, extremes included; one
    // phase runs with no idling on either side.
    task automatic test_random_phases();
        int                    ph;
        logic signed [X_W-1:0] thr;
        longint                mag;
        int unsigned           spread;
        for (ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: thr = 32'h0000_0000;
                1: thr = 32'h0001_8000;
                2: thr = $urandom_range(0, 32'h00FF_FFFF);
                3: thr = 32'hFFFF_FFFF;
                4: thr = 32'h8000_0000;
                5: thr = 32'h7FFF_FFFF;
                default: thr = $urandom();
            endcase
            mag = longint'(thr);
            if (mag < 0)
                mag = -mag;
            if (mag < 64'h2_0000)
                mag = 64'h2_0000;
            if (mag > 64'h4000_0000)
                mag = 64'h4000_0000;
            spread = int'(mag);
            wait_drained();
            set_config(thr, ph[0]);
            if (ph == 3)
            begin
                sample_gap_pct = 0;
                zone_idle_pct  = 0;
            end
            else
            begin
                sample_gap_pct = $urandom_range(10, 50);
                zone_idle_pct  = $urandom_range(10, 50);
            end
            run_streams(56, spread);
        end
    endtask

    // Result receiver: random stalls plus the one-shot long hold-off,
    // counted here in cycles. Ready changes only at falling edges.
    initial
    begin : zone_receiver
        int stall_left;
        stall_left    = 0;
        zone_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (zone_hold_cycles > 0)
            begin
                stall_left       = zone_hold_cycles;
                zone_hold_cycles = 0;
            end
            else if (stall_left == 0 && $urandom_range(0, 99) < zone_idle_pct)
                stall_left = idle_len();
            if (stall_left > 0)
            begin
                zone_bus.ready <= 1'b0;
                stall_left--;
            end
            else
                zone_bus.ready <= 1'b1;
        end
    end

    // Each result transaction is matched against the oldest predicted zone
    always @(posedge clk)
    begin : zone_checker
        zone_result_t want;
        if (rst_n && zone_bus.valid && zone_bus.ready)
        begin
            if (pending_zones.size() == 0)
                report_mismatch("zone with none pending, first/final", 0,
                                {zone_bus.payload.zone_first, zone_bus.payload.zone_final});
            else
            begin
                want = pending_zones.pop_front();
                if (zone_bus.payload.zone_first !== want.zone_first)
                    report_mismatch("zone_first", want.zone_first,
                                    zone_bus.payload.zone_first);
                if (zone_bus.payload.zone_final !== want.zone_final)
                    report_mismatch("zone_final", want.zone_final,
                                    zone_bus.payload.zone_final);
            end
        end
    end

    initial
    begin
        // every block input known from time zero; tracker matches reset state
        rst_n              = 1'b0;
        cfg_write_en       = 1'b0;
        cfg_index          = REG_SPAN_THRESHOLD;
        cfg_data           = '0;
        sample_bus.valid   = 1'b0;
        sample_bus.payload = '0;
        span_thr           = '0;
        widen_on           = 1'b0;
        trk_in_zone        = 1'b0;
        trk_begin_index    = '0;
        trk_begin_x        = '0;
        trk_prev_x         = '0;
        trk_position       = '0;
        mismatch_count     = 0;
        cycle_count        = 0;
        sample_gap_pct     = 0;
        zone_idle_pct      = 0;
        zone_hold_cycles   = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_span_extremes();
        test_widening_edges();
        test_output_backpressure();
        test_random_phases();
        wait_drained();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/qzsd_pkg.sv
rtl/qzsd_stream_if.sv
rtl/qzsd_input_stage.sv
rtl/qzsd_zone_tracker.sv
rtl/qzsd_output_stage.sv
rtl/quiet_zone_span_detector_unit.sv
bench/quiet_zone_span_detector_unit_test.sv
